/* design/psu_pkg.sv */
// Shared types, constants and byte helpers for the PNG scanline unfilter unit.
`default_nettype none

package psu_pkg;

    localparam int          CFG_ADDR_W    = 3;
    localparam int          IMG_WIDTH_W   = 13;
    localparam int          COLOR_MODE_W  = 2;
    localparam int          CLAMP_W       = 15;
    localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

    // register select is paddr[2]
    localparam logic        REG_SEL_WIDTH = 1'b0;
    localparam logic        REG_SEL_MODE  = 1'b1;

    localparam logic [1:0]  MODE_GRAY     = 2'd0;
    localparam logic [1:0]  MODE_RGB      = 2'd1;
    localparam logic [1:0]  MODE_RGBA     = 2'd2;

    localparam logic [2:0]  CHANS_GRAY    = 3'd1;
    localparam logic [2:0]  CHANS_RGB     = 3'd3;
    localparam logic [2:0]  CHANS_RGBA    = 3'd4;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    typedef struct packed {
        logic       bad;
        logic [7:0] data;
        logic [1:0] ch;
        filt_t      filter;
        logic       first_row;
        logic       fresh;
        logic       row_end;
        logic       pix_end;
        logic [2:0] chans;
    } psu_item_t;

    function automatic logic [2:0] chan_count(input logic [1:0] mode);
        case (mode)
            MODE_GRAY: chan_count = CHANS_GRAY;
            MODE_RGB:  chan_count = CHANS_RGB;
            default:   chan_count = CHANS_RGBA;
        endcase
    endfunction

    function automatic logic [7:0] get_byte(input logic [31:0] w, input logic [1:0] ch);
        case (ch)
            2'd0:    get_byte = w[7:0];
            2'd1:    get_byte = w[15:8];
            2'd2:    get_byte = w[23:16];
            default: get_byte = w[31:24];
        endcase
    endfunction

    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] ch,
                                             input logic [7:0] v);
        logic [31:0] r;
        r = w;
        case (ch)
            2'd0:    r[7:0]   = v;
            2'd1:    r[15:8]  = v;
            2'd2:    r[23:16] = v;
            default: r[31:24] = v;
        endcase
        put_byte = r;
    endfunction

endpackage

`default_nettype wire

/* design/psu_row_store.sv */
// Row store: previous scanline bytes, one write and one registered read port.
`default_nettype none

module psu_row_store #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]             rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/psu_row_ctl.sv */
// Row sequencer: filter byte handling, error hold, column and channel tracking.
`default_nettype none

module psu_row_ctl #(
    parameter int ADDR_W = 14,
    parameter int LEN_W  = 15
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [7:0]        in_data,
    input  wire logic              in_start,
    input  wire logic [LEN_W-1:0]  row_len,
    input  wire logic [2:0]        chans,
    output logic                   load,
    output psu_pkg::psu_item_t     item,
    output logic [ADDR_W-1:0]      rd_addr,
    output logic                   rd_en
);
    import psu_pkg::*;

    logic [ADDR_W-1:0] col_reg, col_next;
    logic [1:0]        ch_reg, ch_next;
    logic              ars_reg, ars_next;
    logic              fr_reg, fr_next;
    logic              eh_reg, eh_next;
    filt_t             filt_reg, filt_next;

    logic              eh_eff, fr_eff, ars_eff;
    logic [LEN_W-1:0]  col_inc;
    logic              row_end, pix_end, sample, bad;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            ch_reg   <= '0;
            ars_reg  <= 1'b1;
            fr_reg   <= 1'b1;
            eh_reg   <= 1'b0;
            filt_reg <= FILT_NONE;
        end else begin
            col_reg  <= col_next;
            ch_reg   <= ch_next;
            ars_reg  <= ars_next;
            fr_reg   <= fr_next;
            eh_reg   <= eh_next;
            filt_reg <= filt_next;
        end
    end

    assign eh_eff  = in_start ? 1'b0 : eh_reg;
    assign fr_eff  = in_start ? 1'b1 : fr_reg;
    assign ars_eff = in_start ? 1'b1 : ars_reg;

    assign col_inc = LEN_W'(col_reg) + LEN_W'(1);
    assign row_end = (col_inc >= row_len);
    assign pix_end = row_end || ((3'(ch_reg) + 3'd1) >= chans);

    always_comb begin
        col_next  = col_reg;
        ch_next   = ch_reg;
        ars_next  = ars_reg;
        fr_next   = fr_reg;
        eh_next   = eh_reg;
        filt_next = filt_reg;
        sample    = 1'b0;
        bad       = 1'b0;
        if (accept) begin
            eh_next  = eh_eff;
            fr_next  = fr_eff;
            ars_next = ars_eff;
            if (!eh_eff) begin
                if (ars_eff) begin
                    col_next = '0;
                    ch_next  = '0;
                    if (in_data > 8'(FILT_PAETH)) begin
                        bad     = 1'b1;
                        eh_next = 1'b1;
                    end else begin
                        filt_next = filt_t'(in_data[2:0]);
                        ars_next  = 1'b0;
                    end
                end else begin
                    sample = 1'b1;
                    if (!pix_end) begin
                        ch_next  = ch_reg + 2'd1;
                        col_next = col_inc[ADDR_W-1:0];
                    end else begin
                        ch_next = '0;
                        if (row_end) begin
                            col_next = '0;
                            ars_next = 1'b1;
                            fr_next  = 1'b0;
                        end else begin
                            col_next = col_inc[ADDR_W-1:0];
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        item.bad       = bad;
        item.data      = in_data;
        item.ch        = ch_reg;
        item.filter    = filt_reg;
        item.first_row = fr_reg;
        item.fresh     = (col_reg == '0);
        item.row_end   = row_end && sample;
        item.pix_end   = pix_end && sample;
        item.chans     = chans;
    end

    assign load    = sample || bad;
    assign rd_en   = sample;
    assign rd_addr = col_reg;

endmodule

`default_nettype wire

/* design/psu_recon.sv */
// Reconstruction stage: prediction, pixel assembly and the output register.
`default_nettype none

module psu_recon #(
    parameter int ADDR_W = 14
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire psu_pkg::psu_item_t item_in,
    input  wire logic [ADDR_W-1:0]  col_in,
    input  wire logic [7:0]         rd_data,
    input  wire logic               m_tready,
    output logic                    ready,
    output logic                    wr_en,
    output logic [ADDR_W-1:0]       wr_addr,
    output logic [7:0]              wr_data,
    output logic                    m_tvalid,
    output logic [31:0]             m_tdata,
    output logic                    m_tlast,
    output logic [0:0]              m_tuser
);
    import psu_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    psu_item_t         it_reg;
    logic [ADDR_W-1:0] waddr_reg;
    logic [31:0]       left_reg, left_next;
    logic [31:0]       ul_reg, ul_next;
    logic [23:0]       gather_reg, gather_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_bad_reg, out_bad_next;

    logic              adv, produce;
    logic [31:0]       left_base, ul_base;
    logic [23:0]       gather_base;
    logic [7:0]        a, b, c, pred, val;
    logic [8:0]        sum_ab;
    logic signed [9:0] pa, pb, pc, d_bc, d_ac, d_abc;
    logic [7:0]        px0, px1, px2, px3;

    assign adv   = s1_valid_reg && (!produce || !out_valid_reg || m_tready);
    assign ready = !s1_valid_reg || adv;

    assign left_base   = it_reg.fresh ? '0 : left_reg;
    assign ul_base     = it_reg.fresh ? '0 : ul_reg;
    assign gather_base = it_reg.fresh ? '0 : gather_reg;

    assign a = get_byte(left_base, it_reg.ch);
    assign b = it_reg.first_row ? 8'd0 : rd_data;
    assign c = it_reg.first_row ? 8'd0 : get_byte(ul_base, it_reg.ch);

    assign sum_ab = {1'b0, a} + {1'b0, b};
    assign d_bc   = $signed({2'b00, b}) - $signed({2'b00, c});
    assign d_ac   = $signed({2'b00, a}) - $signed({2'b00, c});
    assign d_abc  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    assign pa     = (d_bc < 0)  ? -d_bc  : d_bc;
    assign pb     = (d_ac < 0)  ? -d_ac  : d_ac;
    assign pc     = (d_abc < 0) ? -d_abc : d_abc;

    always_comb begin
        case (it_reg.filter)
            FILT_SUB: pred = a;
            FILT_UP:  pred = b;
            FILT_AVG: pred = sum_ab[8:1];
            FILT_PAETH: begin
                if (pa <= pb && pa <= pc) begin
                    pred = a;
                end else if (pb <= pc) begin
                    pred = b;
                end else begin
                    pred = c;
                end
            end
            default:  pred = 8'd0;
        endcase
    end

    assign val = it_reg.data + pred;

    always_comb begin
        px0 = gather_base[7:0];
        px1 = gather_base[15:8];
        px2 = gather_base[23:16];
        px3 = 8'd0;
        case (it_reg.ch)
            2'd0:    px0 = val;
            2'd1:    px1 = val;
            2'd2:    px2 = val;
            default: px3 = val;
        endcase
    end

    assign produce = it_reg.bad || it_reg.pix_end;

    always_comb begin
        left_next      = left_reg;
        ul_next        = ul_reg;
        gather_next    = gather_reg;
        s1_valid_next  = load ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        out_valid_next = (adv && produce) ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        if (adv && !it_reg.bad) begin
            left_next = put_byte(left_base, it_reg.ch, val);
            ul_next   = put_byte(ul_base, it_reg.ch, b);
            if (it_reg.pix_end) begin
                gather_next = '0;
            end else if (it_reg.ch != 2'd3) begin
                gather_next = 24'(put_byte({8'd0, gather_base}, it_reg.ch, val));
            end
        end
        if (adv && produce) begin
            out_bad_next  = it_reg.bad;
            out_last_next = it_reg.row_end;
            if (it_reg.bad) begin
                out_data_next = '0;
            end else if (it_reg.chans == CHANS_GRAY) begin
                out_data_next = {ALPHA_OPAQUE, val, val, val};
            end else if (it_reg.chans == CHANS_RGB) begin
                out_data_next = {ALPHA_OPAQUE, px2, px1, px0};
            end else begin
                out_data_next = {px3, px2, px1, px0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            ul_reg        <= '0;
            gather_reg    <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
            ul_reg        <= ul_next;
            gather_reg    <= gather_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            it_reg    <= item_in;
            waddr_reg <= col_in;
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    assign wr_en   = adv && !it_reg.bad;
    assign wr_addr = waddr_reg;
    assign wr_data = val;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_bad_reg;

endmodule

`default_nettype wire

/* design/png_scanline_unfilter_unit.sv */
// Top level of the PNG scanline unfilter unit: config registers and stage wiring.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: data_byte; s_tuser: image_start
//  m_      | out | m_tvalid/m_tready  | m_tdata: red,green,blue,alpha; m_tlast;
//          |     |                    | m_tuser: bad_filter
//  apb     | in  | psel/penable       | 0x0 image_width, 0x4 color_mode
//
// One transaction per cycle unless stalled; each result is staged, then registered.
// The row store read is issued on the accepting edge, so the prediction stage
// has it registered in the next cycle. No clearing pass after reset: the row
// store output is ignored on the first row of an image. Input stalls only
// when the output register holds an untaken result and a result is pending.
`default_nettype none

module png_scanline_unfilter_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // APB
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [psu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]                    s_tuser,   // [0] image_start
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,   // red, green, blue, alpha
    output logic                               m_tlast,   // row_last
    output logic [0:0]                         m_tuser    // [0] bad_filter
);
    import psu_pkg::*;

    localparam int                 DEPTH    = MAX_WIDTH * 4;
    localparam int                 ADDR_W   = $clog2(DEPTH);
    localparam int                 LEN_W    = $clog2(DEPTH + 1);
    localparam logic [CLAMP_W-1:0] MAX_W_C  = CLAMP_W'(MAX_WIDTH);

    logic [IMG_WIDTH_W-1:0]  image_width_reg;
    logic [COLOR_MODE_W-1:0] color_mode_reg;
    logic                    cfg_wr;

    logic [CLAMP_W-1:0] w_clamp;
    logic [LEN_W-1:0]   w_len, row_len;
    logic [2:0]         chans;

    logic               accept, load, rd_en, wr_en;
    psu_item_t          item;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [7:0]         rd_data, wr_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= IMG_WIDTH_W'(1);
            color_mode_reg  <= MODE_RGBA;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SEL_WIDTH) begin
                image_width_reg <= pwdata[IMG_WIDTH_W-1:0];
            end else begin
                color_mode_reg <= pwdata[COLOR_MODE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SEL_MODE) ? {30'd0, color_mode_reg}
                                               : {19'd0, image_width_reg};

    always_comb begin
        if (image_width_reg == '0) begin
            w_clamp = CLAMP_W'(1);
        end else if (CLAMP_W'(image_width_reg) > MAX_W_C) begin
            w_clamp = MAX_W_C;
        end else begin
            w_clamp = CLAMP_W'(image_width_reg);
        end
    end

    assign w_len = LEN_W'(w_clamp);
    assign chans = chan_count(color_mode_reg);

    always_comb begin
        case (chans)
            CHANS_GRAY: row_len = w_len;
            CHANS_RGB:  row_len = w_len + (w_len << 1);
            default:    row_len = w_len << 2;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    psu_row_ctl #(
        .ADDR_W (ADDR_W),
        .LEN_W  (LEN_W)
    ) u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_data  (s_tdata),
        .in_start (s_tuser[0]),
        .row_len  (row_len),
        .chans    (chans),
        .load     (load),
        .item     (item),
        .rd_addr  (rd_addr),
        .rd_en    (rd_en)
    );

    psu_row_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    psu_recon #(
        .ADDR_W (ADDR_W)
    ) u_recon (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .item_in  (item),
        .col_in   (rd_addr),
        .rd_data  (rd_data),
        .m_tready (m_tready),
        .ready    (s_tready),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_load_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> accept)
        else $error("stage load without an input transaction");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("row store read and write hit the same column");

    a_bad_result_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tlast))
        else $error("bad filter result carries pixel data");

endmodule

`default_nettype wire
